@@ design/rpc_pkg.sv @@
// Shared types, breakpoint tables and segment lookup for the rpm correction pipeline.
`default_nettype none
package rpc_pkg;

  localparam int unsigned NumKeys  = 17;
  localparam int unsigned NumSegs  = NumKeys - 1;
  localparam int unsigned RpmW     = 14;
  localparam int unsigned OutW     = 15;
  localparam int unsigned SegW     = 5;
  localparam int unsigned OffW     = 13;
  localparam int unsigned NumW     = 5;
  localparam int unsigned ShW      = 2;
  localparam int unsigned ProdW    = OffW + NumW;
  localparam int unsigned RecipW   = 15;
  localparam int unsigned MulW     = ProdW + RecipW;
  localparam int unsigned RecipSh  = 17;
  localparam int unsigned QuoW     = MulW - RecipSh;
  localparam logic [RecipW-1:0] Div5Recip = 15'd26215;
  localparam logic [RpmW-1:0]   PassLimit = 14'd250;
  localparam logic [OutW-1:0]   MaxOut    = 15'd16883;

  localparam logic [OutW-1:0] KeyIn [NumKeys] = '{
    15'd200,  15'd400,  15'd600,  15'd800,  15'd1000, 15'd2000, 15'd3000, 15'd4000,
    15'd5000, 15'd6000, 15'd7000, 15'd8000, 15'd9000, 15'd10000, 15'd11000, 15'd15500,
    15'd20000
  };

  localparam logic [OutW-1:0] KeyOut [NumKeys] = '{
    15'd225,  15'd450,  15'd675,  15'd900,  15'd1150, 15'd2200, 15'd3250, 15'd4300,
    15'd5400, 15'd6500, 15'd7500, 15'd8500, 15'd9500, 15'd10500, 15'd11500, 15'd16000,
    15'd20500
  };

  // reduced slope of each segment: num / (2^shift * (div5 ? 5 : 1))
  localparam logic [NumW-1:0] SegNum [NumSegs] = '{
    5'd9, 5'd9, 5'd9, 5'd5, 5'd21, 5'd21, 5'd21, 5'd11,
    5'd11, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1
  };
  localparam logic [ShW-1:0] SegShift [NumSegs] = '{
    2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1,
    2'd1, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0
  };
  localparam logic SegDiv5 [NumSegs] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
  };

  typedef struct packed {
    logic [RpmW-1:0] lo_in;
    logic [OutW-1:0] lo_out;
    logic [NumW-1:0] num;
    logic [ShW-1:0]  shift;
    logic            div5;
  } seg_info_t;

  typedef struct packed {
    logic [RpmW-1:0] rpm;
    logic [SegW-1:0] seg;
    logic            pass;
  } loc_t;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [ShW-1:0]   shift;
    logic             div5;
    logic [OutW-1:0]  lo_out;
    logic             pass;
    logic [RpmW-1:0]  rpm;
  } scl_t;

  typedef struct packed {
    logic [MulW-1:0] mul;
    logic            div5;
    logic [OutW-1:0] lo_out;
    logic            pass;
    logic [RpmW-1:0] rpm;
  } quo_t;

  function automatic seg_info_t seg_info(input logic [SegW-1:0] seg);
    seg_info_t       info;
    logic [SegW-1:0] idx;
    idx         = seg - 5'd1;
    info.lo_in  = '0;
    info.lo_out = KeyOut[NumKeys-1];
    info.num    = '0;
    info.shift  = '0;
    info.div5   = 1'b0;
    if (seg == '0) begin
      info.lo_out = KeyOut[0];
    end else if (seg < SegW'(NumKeys)) begin
      info.lo_in  = KeyIn[idx][RpmW-1:0];
      info.lo_out = KeyOut[idx];
      info.num    = SegNum[idx[3:0]];
      info.shift  = SegShift[idx[3:0]];
      info.div5   = SegDiv5[idx[3:0]];
    end
    return info;
  endfunction

endpackage
`default_nettype wire

@@ design/rpm_piecewise_linear_correction.sv @@
// Top level: four-stage piecewise linear rpm correction with output register.
//
//  beat      | direction | handshake                | payload
//  ----------+-----------+--------------------------+----------------------------------
//  in        | in        | in_valid_i / in_ready_o   | rpm_high_byte_i, rpm_low_byte_i
//  out       | out       | out_valid_o / out_ready_i | corrected_rpm_o
//
// out_valid_o rises once an accepted in beat has passed the locate, scale, divide and output registers;
// one beat per cycle while out_ready_i does not stall the pipeline. Stages: segment search, slope multiply,
// reciprocal divide, add and output register. Each stage holds its own valid bit; ready ripples back so
// bubbles are squeezed out. Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module rpm_piecewise_linear_correction (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  rpm_high_byte_i,
  input  wire logic [7:0]  rpm_low_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [14:0]      corrected_rpm_o
);
  import rpc_pkg::*;

  logic            loc_valid, loc_ready;
  loc_t            loc;
  logic            scl_valid, scl_ready;
  scl_t            scl;
  logic            quo_valid, quo_ready;
  quo_t            quo;
  logic            out_valid_q;
  logic [OutW-1:0] out_q, out_d;
  logic [QuoW-1:0] quot;
  logic [OutW-1:0] sum;

  rpc_locate u_locate (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rpm_high_byte_i (rpm_high_byte_i),
    .rpm_low_byte_i  (rpm_low_byte_i),
    .out_valid_o     (loc_valid),
    .out_ready_i     (loc_ready),
    .out_o           (loc)
  );

  rpc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (loc_valid),
    .in_ready_o  (loc_ready),
    .in_i        (loc),
    .out_valid_o (scl_valid),
    .out_ready_i (scl_ready),
    .out_o       (scl)
  );

  rpc_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (scl_valid),
    .in_ready_o  (scl_ready),
    .in_i        (scl),
    .out_valid_o (quo_valid),
    .out_ready_i (quo_ready),
    .out_o       (quo)
  );

  always_comb begin
    quot  = quo.div5 ? quo.mul[MulW-1:RecipSh] : quo.mul[QuoW-1:0];
    sum   = quo.lo_out + quot[OutW-1:0];
    out_d = quo.pass ? {1'b0, quo.rpm} : sum;
  end

  assign quo_ready       = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign corrected_rpm_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (quo_ready) begin
      out_valid_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quo_ready && quo_valid) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipeline stalls with an empty output register");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> corrected_rpm_o <= MaxOut)
    else $error("corrected rpm out of range");

  a_seg_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loc_valid && !loc.pass |-> loc.seg != '0 && loc.seg < SegW'(NumKeys))
    else $error("segment search fell outside the table");
`endif

endmodule
`default_nettype wire

@@ design/rpc_locate.sv @@
// Stage one: form raw rpm and find its breakpoint segment.
`default_nettype none
module rpc_locate (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     rpm_high_byte_i,
  input  wire logic [7:0]     rpm_low_byte_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rpc_pkg::loc_t       out_o
);
  import rpc_pkg::*;

  logic                valid_q;
  loc_t                data_q, data_d;
  logic [RpmW-1:0]     rpm;
  logic [NumKeys-1:0]  below;

  assign rpm = {rpm_high_byte_i, rpm_low_byte_i[7:2]};

  always_comb begin
    for (int j = 0; j < NumKeys; j++) begin
      below[j] = KeyIn[j] < {1'b0, rpm};
    end
    data_d.rpm  = rpm;
    data_d.seg  = SegW'($countones(below));
    data_d.pass = rpm < PassLimit;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

@@ design/rpc_scale.sv @@
// Stage two: segment lookup and offset times reduced slope numerator.
`default_nettype none
module rpc_scale (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rpc_pkg::loc_t in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rpc_pkg::scl_t  out_o
);
  import rpc_pkg::*;

  logic            valid_q;
  scl_t            data_q, data_d;
  seg_info_t       info;
  logic [RpmW-1:0] diff;
  logic [OffW-1:0] off;

  always_comb begin
    info           = seg_info(in_i.seg);
    diff           = in_i.rpm - info.lo_in;
    off            = diff[OffW-1:0];
    data_d.prod    = ProdW'(off) * ProdW'(info.num);
    data_d.shift   = info.shift;
    data_d.div5    = info.div5;
    data_d.lo_out  = info.lo_out;
    data_d.pass    = in_i.pass;
    data_d.rpm     = in_i.rpm;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

@@ design/rpc_divide.sv @@
// Stage three: power-of-two shift and reciprocal multiply for the divide by five.
`default_nettype none
module rpc_divide (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire rpc_pkg::scl_t in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output rpc_pkg::quo_t  out_o
);
  import rpc_pkg::*;

  logic             valid_q;
  quo_t             data_q, data_d;
  logic [ProdW-1:0] shifted;

  always_comb begin
    shifted        = in_i.prod >> in_i.shift;
    data_d.mul     = in_i.div5 ? MulW'(shifted) * MulW'(Div5Recip) : MulW'(shifted);
    data_d.div5    = in_i.div5;
    data_d.lo_out  = in_i.lo_out;
    data_d.pass    = in_i.pass;
    data_d.rpm     = in_i.rpm;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

@@ sim/rpm_piecewise_linear_correction_tb.sv @@
// Testbench for rpm_piecewise_linear_correction: directed table then random beats against a predictor.
`timescale 1ns / 1ps
module rpm_piecewise_linear_correction_tb;

  localparam int unsigned NumKnees = 17;
  localparam int unsigned KneeRpm [NumKnees] = '{
    200, 400, 600, 800, 1000, 2000, 3000, 4000, 5000,
    6000, 7000, 8000, 9000, 10000, 11000, 15500, 20000
  };
  localparam int unsigned KneeOut [NumKnees] = '{
    225, 450, 675, 900, 1150, 2200, 3250, 4300, 5400,
    6500, 7500, 8500, 9500, 10500, 11500, 16000, 20500
  };
  localparam int unsigned PassBelow   = 250;
  localparam int unsigned RandomBeats = 700;
  localparam int unsigned DrainLimit  = 20000;

  typedef struct packed {
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        known;
    logic [14:0] want;
  } speed_row_t;

  localparam int unsigned NumRows = 22;
  localparam speed_row_t SpeedRows [NumRows] = '{
    '{8'h00, 8'h00, 1'b1, 15'd0},
    '{8'h00, 8'h03, 1'b1, 15'd0},
    '{8'h03, 8'h20, 1'b1, 15'd200},
    '{8'h03, 8'hE4, 1'b1, 15'd249},
    '{8'h03, 8'hE7, 1'b1, 15'd249},
    '{8'h03, 8'hE8, 1'b1, 15'd281},
    '{8'h06, 8'h40, 1'b1, 15'd450},
    '{8'h09, 8'h60, 1'b1, 15'd675},
    '{8'h0C, 8'h80, 1'b1, 15'd900},
    '{8'h0F, 8'hA0, 1'b1, 15'd1150},
    '{8'h1F, 8'h40, 1'b1, 15'd2200},
    '{8'hAB, 8'hE0, 1'b1, 15'd11500},
    '{8'hF2, 8'h30, 1'b1, 15'd16000},
    '{8'hFF, 8'hFF, 1'b1, 15'd16883},
    '{8'hFF, 8'h00, 1'b1, 15'd16820},
    '{8'h00, 8'hFF, 1'b0, 15'd0},
    '{8'h80, 8'h00, 1'b0, 15'd0},
    '{8'h55, 8'hAA, 1'b0, 15'd0},
    '{8'hAA, 8'h55, 1'b0, 15'd0},
    '{8'h12, 8'hC1, 1'b0, 15'd0},
    '{8'h75, 8'h31, 1'b0, 15'd0},
    '{8'hF2, 8'h34, 1'b0, 15'd0}
  };

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rpm_high_byte_i = 8'h00;
  logic [7:0]  rpm_low_byte_i  = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i     = 1'b0;
  logic [14:0] corrected_rpm_o;

  logic [14:0] speed_q [$];
  int unsigned accepted_beats = 0;
  int unsigned checked_beats  = 0;
  int unsigned mismatches     = 0;
  int unsigned stall_left     = 0;
  bit          steady         = 1'b0;

  rpm_piecewise_linear_correction dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rpm_high_byte_i (rpm_high_byte_i),
    .rpm_low_byte_i  (rpm_low_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .corrected_rpm_o (corrected_rpm_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("%0t: timeout with %0d results outstanding", $time, speed_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [14:0] corrected_speed(input logic [7:0] hi, input logic [7:0] lo);
    int unsigned rpm;
    int unsigned seg;
    int unsigned span_in;
    int unsigned span_out;
    rpm = {hi, lo} >> 2;
    if (rpm < PassBelow) return 15'(rpm);
    seg = 0;
    while (seg < NumKnees && KneeRpm[seg] < rpm) seg++;
    if (seg == 0) return 15'(KneeOut[0]);
    if (seg >= NumKnees) return 15'(KneeOut[NumKnees-1]);
    span_in  = KneeRpm[seg] - KneeRpm[seg-1];
    span_out = KneeOut[seg] - KneeOut[seg-1];
    return 15'(KneeOut[seg-1] + ((rpm - KneeRpm[seg-1]) * span_out) / span_in);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // hold each beat until accepted, then idle for a random gap (none while steady)
  task automatic send_beat(input logic [7:0] hi, input logic [7:0] lo, input logic known,
                           input logic [14:0] want);
    int unsigned gap;
    in_valid_i      <= 1'b1;
    rpm_high_byte_i <= hi;
    rpm_low_byte_i  <= lo;
    do @(posedge clk_i); while (!in_ready_o);
    speed_q.push_back(known ? want : corrected_speed(hi, lo));
    accepted_beats++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    int unsigned cycles;
    cycles = 0;
    while (speed_q.size() != 0 && cycles < DrainLimit) begin
      @(posedge clk_i);
      cycles++;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (speed_q.size() == 0) begin
        mismatches++;
        $display("%0t: corrected_rpm expected none, got %0d", $time, corrected_rpm_o);
      end else begin
        if (corrected_rpm_o !== speed_q[0]) begin
          mismatches++;
          $display("%0t: corrected_rpm expected %0d, got %0d", $time, speed_q[0],
                   corrected_rpm_o);
        end
        void'(speed_q.pop_front());
        checked_beats++;
      end
    end
  end

  initial begin
    int          raw;
    int unsigned pick;
    logic [7:0]  hi;
    logic [7:0]  lo;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) begin
      send_beat(SpeedRows[i].hi, SpeedRows[i].lo, SpeedRows[i].known, SpeedRows[i].want);
    end

    // drop valid and hold off until the pipeline is empty
    in_valid_i <= 1'b0;
    wait_drained();

    for (int i = 0; i < RandomBeats; i++) begin
      steady = ((i / 100) % 3) == 1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        hi = 8'($urandom);
        lo = 8'($urandom);
      end else begin
        if (pick < 85) begin
          raw = (int'(KneeRpm[$urandom_range(0, NumKnees - 2)]) + int'($urandom_range(0, 6)) - 3)
                * 4 + int'($urandom_range(0, 3));
        end else begin
          raw = int'($urandom_range(0, 1200));
        end
        hi = raw[15:8];
        lo = raw[7:0];
      end
      send_beat(hi, lo, 1'b0, 15'd0);
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (speed_q.size() != 0) begin
      mismatches++;
      $display("%0t: corrected_rpm expected %0d more results, got none", $time,
               speed_q.size());
    end

    $display("Run covered %0d accepted beats and %0d checked results (%0d mismatches),",
             accepted_beats, checked_beats, mismatches);
    $display("spanning pass-through, knee values, every segment and full-scale input.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ rpm_piecewise_linear_correction.f @@
design/rpc_pkg.sv
design/rpc_locate.sv
design/rpc_scale.sv
design/rpc_divide.sv
design/rpm_piecewise_linear_correction.sv
sim/rpm_piecewise_linear_correction_tb.sv
